// ===== src/ubd_pkg.sv =====
// Shared types, constants and codes for the USART baud divisor selector.
package ubd_pkg;

    // Field and register widths
    localparam int BAUD_W          = 32;
    localparam int MODE_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int CLOCK_W         = 32;
    localparam int TOL_W           = 7;
    localparam int CFG_DATA_W      = 32;
    localparam int CFG_INDEX_W     = 1;
    localparam int DIVISOR_OUT_W   = 16;
    localparam int DIVISOR_WIDTH_DEF = 16;

    // Register reset values
    localparam logic [CLOCK_W-1:0] CLOCK_HZ_RST = CLOCK_W'(16000000);
    localparam logic [TOL_W-1:0]   TOL_PCT_RST  = TOL_W'(2);

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_HZ = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOL_PCT  = 1'b1;

    // Mode codes
    localparam logic [MODE_W-1:0] MODE_ASYNC       = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SYNC_MASTER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SYNC_SLAVE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_INVALID     = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNREACHABLE = 2'd2;

    // Oversampling factors and their log2
    localparam int F_ASYNC   = 16;
    localparam int F_DOUBLE  = 8;
    localparam int F_SYNC    = 2;
    localparam int SH_ASYNC  = 4;
    localparam int SH_DOUBLE = 3;
    localparam int SH_SYNC   = 1;

    // Percent scale and derived widths
    localparam int PCT_SCALE = 100;
    localparam int PCT_W     = 8;     // holds 100 + tolerance
    localparam int LHS_W     = CLOCK_W + 7;

    // Divider: clock_hz / baud_rate, restoring, DIV_STEP bits per stage
    localparam int DIV_W      = 32;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = DIV_W / DIV_STEP;

    typedef struct packed {
        logic [BAUD_W-1:0] baud;
        logic [MODE_W-1:0] mode;
        logic              bad;   // zero baud or invalid mode
    } req_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dq;     // dividend bits out, quotient bits in
        logic [DIV_W-1:0] den;
        req_t             req;
    } dstage_t;

endpackage

// ===== src/ubd_divider.sv =====
// Pipelined restoring divider: quotient of clock_hz over the requested baud.
module ubd_divider import ubd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CLOCK_W-1:0]  clock_hz,
    input  logic                in_valid,
    output logic                in_ready,
    input  req_t                in_req,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [DIV_W-1:0]    out_quot,
    output req_t                out_req
);

    function automatic dstage_t div_step(dstage_t s);
        dstage_t          r;
        logic [DIV_W:0]   t;
        r = s;
        for (int i = 0; i < DIV_STEP; i++) begin
            t = {r.rem, r.dq[DIV_W-1]};
            if (t >= {1'b0, r.den}) begin
                r.rem = DIV_W'(t - {1'b0, r.den});
                r.dq  = {r.dq[DIV_W-2:0], 1'b1};
            end else begin
                r.rem = t[DIV_W-1:0];
                r.dq  = {r.dq[DIV_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    dstage_t                 st_reg  [DIV_STAGES];
    dstage_t                 st_next [DIV_STAGES];
    logic [DIV_STAGES-1:0]   vld_reg;
    logic [DIV_STAGES-1:0]   adv;
    dstage_t                 first;

    always_comb begin
        first.rem = '0;
        first.dq  = clock_hz;
        first.den = in_req.baud;
        first.req = in_req;
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_comb st_next[k] = div_step(first);
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (adv[k]) begin
                    vld_reg[k] <= in_valid;
                end
            end
        end else begin : g_rest
            always_comb st_next[k] = div_step(st_reg[k-1]);
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (adv[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end

        if (k == DIV_STAGES - 1) begin : g_last
            assign adv[k] = !vld_reg[k] || out_ready;
        end else begin : g_mid
            assign adv[k] = !vld_reg[k] || adv[k+1];
        end

        always_ff @(posedge aclk) begin
            if (adv[k]) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_quot  = st_reg[DIV_STAGES-1].dq;
    assign out_req   = st_reg[DIV_STAGES-1].req;

endmodule

// ===== src/ubd_check.sv =====
// Candidate divisors, rate error check against tolerance, and result register.
module ubd_check import ubd_pkg::*; #(
    parameter int DIVISOR_WIDTH = DIVISOR_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [CLOCK_W-1:0]         clock_hz,
    input  logic [TOL_W-1:0]           tolerance_pct,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [DIV_W-1:0]           in_quot,
    input  req_t                       in_req,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [DIVISOR_OUT_W-1:0]   out_divisor,
    output logic                       out_double_speed,
    output logic [STATUS_W-1:0]        out_status
);

    localparam int DW  = DIVISOR_WIDTH;
    localparam int M_W = DW + 1 + BAUD_W;       // (div+1) * baud
    localparam int T_W = M_W + PCT_W;           // times (100 +/- tol)
    localparam int P_W = T_W + SH_ASYNC;        // times f

    localparam int NSTG = 4;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] adv;

    assign adv[0] = !vld_reg[0] || adv[1];
    assign adv[1] = !vld_reg[1] || adv[2];
    assign adv[2] = !vld_reg[2] || adv[3];
    assign adv[3] = !vld_reg[3] || out_ready;
    assign in_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) vld_reg[0] <= in_valid;
            if (adv[1]) vld_reg[1] <= vld_reg[0];
            if (adv[2]) vld_reg[2] <= vld_reg[1];
            if (adv[3]) vld_reg[3] <= vld_reg[2];
        end
    end

    // ---- stage 1: rounded quotients and candidate divisors
    // floor((clk + f/2*b) / (f*b)) == (floor(clk/b) + f/2) >> log2(f)
    logic              is_async;
    logic [DIV_W:0]    qa_next, qb_next;
    logic [DIV_W:0]    qa_m1, qb_m1;
    logic [DW-1:0]     da_next, db_next;
    logic [DW-1:0]     s1_da_reg, s1_db_reg;
    logic [DW:0]       s1_dpa_reg, s1_dpb_reg;
    logic [BAUD_W-1:0] s1_baud_reg;
    logic              s1_async_reg, s1_bad_reg;

    always_comb begin
        is_async = (in_req.mode == MODE_ASYNC);
        if (is_async) begin
            qa_next = ({1'b0, in_quot} + (DIV_W+1)'(F_ASYNC / 2)) >> SH_ASYNC;
        end else begin
            qa_next = ({1'b0, in_quot} + (DIV_W+1)'(F_SYNC / 2)) >> SH_SYNC;
        end
        qb_next = ({1'b0, in_quot} + (DIV_W+1)'(F_DOUBLE / 2)) >> SH_DOUBLE;
        qa_m1   = qa_next - (DIV_W+1)'(1);
        qb_m1   = qb_next - (DIV_W+1)'(1);
        da_next = qa_m1[DW-1:0];
        db_next = qb_m1[DW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            s1_da_reg    <= da_next;
            s1_db_reg    <= db_next;
            s1_dpa_reg   <= {1'b0, da_next} + (DW+1)'(1);
            s1_dpb_reg   <= {1'b0, db_next} + (DW+1)'(1);
            s1_baud_reg  <= in_req.baud;
            s1_async_reg <= is_async;
            s1_bad_reg   <= in_req.bad;
        end
    end

    // ---- stage 2: (div+1) * baud
    logic [DW-1:0]  s2_da_reg, s2_db_reg;
    logic [M_W-1:0] s2_ma_reg, s2_mb_reg;
    logic           s2_async_reg, s2_bad_reg;

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            s2_da_reg    <= s1_da_reg;
            s2_db_reg    <= s1_db_reg;
            s2_ma_reg    <= M_W'(s1_dpa_reg) * M_W'(s1_baud_reg);
            s2_mb_reg    <= M_W'(s1_dpb_reg) * M_W'(s1_baud_reg);
            s2_async_reg <= s1_async_reg;
            s2_bad_reg   <= s1_bad_reg;
        end
    end

    // ---- stage 3: scale by (100 +/- tol) and by f
    logic           lo_en;
    logic [PCT_W-1:0] pct_hi, pct_lo;
    logic [T_W-1:0] ta_hi, ta_lo, tb_hi, tb_lo;
    logic [P_W-1:0] s3_pa_hi_reg, s3_pa_lo_reg, s3_pb_hi_reg, s3_pb_lo_reg;
    logic [DW-1:0]  s3_da_reg, s3_db_reg;
    logic           s3_async_reg, s3_bad_reg;

    always_comb begin
        lo_en  = (tolerance_pct < TOL_W'(PCT_SCALE));
        pct_hi = PCT_W'(PCT_SCALE) + {1'b0, tolerance_pct};
        pct_lo = lo_en ? (PCT_W'(PCT_SCALE) - {1'b0, tolerance_pct}) : '0;
        ta_hi  = T_W'(s2_ma_reg) * T_W'(pct_hi);
        ta_lo  = T_W'(s2_ma_reg) * T_W'(pct_lo);
        tb_hi  = T_W'(s2_mb_reg) * T_W'(pct_hi);
        tb_lo  = T_W'(s2_mb_reg) * T_W'(pct_lo);
    end

    always_ff @(posedge aclk) begin
        if (adv[2]) begin
            if (s2_async_reg) begin
                s3_pa_hi_reg <= P_W'(ta_hi) << SH_ASYNC;
                s3_pa_lo_reg <= P_W'(ta_lo) << SH_ASYNC;
            end else begin
                s3_pa_hi_reg <= P_W'(ta_hi) << SH_SYNC;
                s3_pa_lo_reg <= P_W'(ta_lo) << SH_SYNC;
            end
            s3_pb_hi_reg <= P_W'(tb_hi) << SH_DOUBLE;
            s3_pb_lo_reg <= P_W'(tb_lo) << SH_DOUBLE;
            s3_da_reg    <= s2_da_reg;
            s3_db_reg    <= s2_db_reg;
            s3_async_reg <= s2_async_reg;
            s3_bad_reg   <= s2_bad_reg;
        end
    end

    // ---- stage 4: compare against 100 * clock, pick result
    logic [LHS_W-1:0]         lhs;
    logic [P_W-1:0]           lhs_ext;
    logic                     ok_a, ok_b;
    logic [DIVISOR_OUT_W-1:0] div_next;
    logic                     ds_next;
    logic [STATUS_W-1:0]      st_next;
    logic [DIVISOR_OUT_W-1:0] div_reg;
    logic                     ds_reg;
    logic [STATUS_W-1:0]      st_reg;

    always_comb begin
        lhs     = LHS_W'(clock_hz) * LHS_W'(PCT_SCALE);
        lhs_ext = P_W'(lhs);
        ok_a = !(lhs_ext > s3_pa_hi_reg) && !(lo_en && (lhs_ext < s3_pa_lo_reg));
        ok_b = !(lhs_ext > s3_pb_hi_reg) && !(lo_en && (lhs_ext < s3_pb_lo_reg));
        div_next = '0;
        ds_next  = 1'b0;
        st_next  = STATUS_OK;
        if (s3_bad_reg) begin
            st_next = STATUS_INVALID;
        end else if (ok_a) begin
            div_next = DIVISOR_OUT_W'(s3_da_reg);
        end else if (s3_async_reg && ok_b) begin
            div_next = DIVISOR_OUT_W'(s3_db_reg);
            ds_next  = 1'b1;
        end else begin
            st_next = STATUS_UNREACHABLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[3]) begin
            div_reg <= div_next;
            ds_reg  <= ds_next;
            st_reg  <= st_next;
        end
    end

    assign out_valid        = vld_reg[3];
    assign out_divisor      = div_reg;
    assign out_double_speed = ds_reg;
    assign out_status       = st_reg;

endmodule

// ===== src/usart_baud_divisor_select.sv =====
// Top level of the USART baud divisor selector: config registers, divider, checker.
//
// Turns a requested baud rate and USART mode into a baud register divisor, a
// double-speed flag and a status, for the clock and tolerance held in the two
// configuration registers (clock_hz at index 0, tolerance_pct at index 1). The
// divisor is round(clock / (f*baud)) - 1 kept to DIVISOR_WIDTH bits, accepted
// when f*(divisor+1)*baud is within +/- tolerance_pct percent of the clock; async
// tries f=16 then f=8 (double speed), the sync modes use f=2. A zero baud or
// mode 3 reports invalid. Fully pipelined: one beat in and one beat out per
// cycle with no back-pressure. The divider for clock/baud retires two quotient
// bits per stage; after it come candidate rounding, the (div+1)*baud multiply,
// the percent/factor scaling and the final compare into the output register.
// Each stage stalls only when it is full and the one after it is stalled, so
// bubbles collapse and a new beat can be taken while a finished result waits
// on m_ready while some stage is empty. Write the configuration only while the
// pipeline is empty.
module usart_baud_divisor_select import ubd_pkg::*; #(
    parameter int DIVISOR_WIDTH = DIVISOR_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    // request channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [BAUD_W-1:0]         s_baud_rate,
    input  logic [MODE_W-1:0]         s_mode,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [DIVISOR_OUT_W-1:0]  m_divisor,
    output logic                      m_double_speed,
    output logic [STATUS_W-1:0]       m_status
);

    // Configuration registers
    logic [CLOCK_W-1:0] clock_hz_reg;
    logic [TOL_W-1:0]   tol_pct_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clock_hz_reg <= CLOCK_HZ_RST;
            tol_pct_reg  <= TOL_PCT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_CLOCK_HZ: clock_hz_reg <= cfg_wdata[CLOCK_W-1:0];
                CFG_TOL_PCT:  tol_pct_reg  <= cfg_wdata[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // Request beat, with the invalid-argument flag decided up front
    req_t in_req;
    always_comb begin
        in_req.baud = s_baud_rate;
        in_req.mode = s_mode;
        in_req.bad  = (s_baud_rate == '0) || (s_mode == MODE_INVALID);
    end

    logic             dv_valid, dv_ready;
    logic [DIV_W-1:0] dv_quot;
    req_t             dv_req;

    ubd_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clock_hz  (clock_hz_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_req    (in_req),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_quot  (dv_quot),
        .out_req   (dv_req)
    );

    ubd_check #(
        .DIVISOR_WIDTH (DIVISOR_WIDTH)
    ) u_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .clock_hz         (clock_hz_reg),
        .tolerance_pct    (tol_pct_reg),
        .in_valid         (dv_valid),
        .in_ready         (dv_ready),
        .in_quot          (dv_quot),
        .in_req           (dv_req),
        .out_valid        (m_valid),
        .out_ready        (m_ready),
        .out_divisor      (m_divisor),
        .out_double_speed (m_double_speed),
        .out_status       (m_status)
    );

    // A failed request never carries a divisor or the double-speed flag.
    a_fail_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_OK) |-> (m_divisor == '0) && !m_double_speed)
        else $error("non-ok result carries divisor or double-speed");

    // Double speed only comes with an ok status.
    a_ds_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_double_speed |-> (m_status == STATUS_OK))
        else $error("double-speed set on a failed result");

    // Input back-pressure only originates from a stalled output beat.
    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled while output is free");

    // Status is always one of the defined codes.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STATUS_OK) || (m_status == STATUS_INVALID)
                    || (m_status == STATUS_UNREACHABLE))
        else $error("undefined status code");

endmodule
